@@ hdl/cee_pkg.sv @@
`timescale 1ns / 1ps
// cee_pkg: shared constants, types and the character table of the escape expander
// no dependencies

package cee_pkg;

  localparam int unsigned MaskW   = 64;
  localparam int unsigned NumMask = 4;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned MaxOut  = 5;
  localparam int unsigned CntW    = 3;

  localparam logic [CfgIdxW-1:0] CfgEscape0    = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgEscape1    = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgEscape2    = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgEscape3    = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgException0 = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgException1 = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgException2 = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgException3 = 4'd7;

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] Nul       = 8'h00;
  localparam logic [7:0] PrintLo   = 8'h20;
  localparam logic [7:0] PrintHi   = 8'h7E;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] chars;
    logic [CntW-1:0]        cnt;
  } exp_t;

  typedef struct packed {
    logic [NumMask*MaskW-1:0] escape;
    logic [NumMask*MaskW-1:0] exception;
  } masks_t;

  // letter for the standard escapes 7..13, zero when none applies
  function automatic logic [7:0] short_escape(input logic [7:0] v);
    logic [7:0] letter;
    unique case (v)
      8'd7:    letter = 8'h61; // a
      8'd8:    letter = 8'h62; // b
      8'd9:    letter = 8'h74; // t
      8'd10:   letter = 8'h6E; // n
      8'd11:   letter = 8'h76; // v
      8'd12:   letter = 8'h66; // f
      8'd13:   letter = 8'h72; // r
      default: letter = Nul;
    endcase
    return letter;
  endfunction

endpackage

@@ hdl/c_escape_expander.sv @@
`timescale 1ns / 1ps
// c_escape_expander: top level; a source byte is registered, expanded, then sent
// through an output shifter one char per beat; the expansion is combinational.
// throughput: one output beat per cycle unless out_stall; an item gives one beat per
// char of its 1 to 5 char expansion; the next item is taken as the last beat leaves.
// reset: synchronous active-high rst clears all masks and empties both stages.
// depends on cee_pkg, cee_cfg, cee_expand, cee_serial

module c_escape_expander (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cee_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [cee_pkg::MaskW-1:0]   cfg_data,
  input  logic                        src_valid,
  output logic                        src_stall,
  input  logic [7:0]                  src_byte,
  input  logic                        src_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_char,
  output logic                        out_last
);

  cee_pkg::masks_t masks;
  cee_pkg::exp_t   exp;
  logic            exp_valid;
  logic            take;

  cee_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .masks     (masks)
  );

  cee_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_byte  (src_byte),
    .src_last  (src_last),
    .masks     (masks),
    .take      (take),
    .exp_valid (exp_valid),
    .exp       (exp)
  );

  cee_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .exp_valid (exp_valid),
    .exp       (exp),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

@@ hdl/cee_cfg.sv @@
`timescale 1ns / 1ps
// cee_cfg: escape and exception mask registers behind the write port
// depends on cee_pkg

module cee_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cee_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cee_pkg::MaskW-1:0]      cfg_data,
  output cee_pkg::masks_t                masks
);

  logic [cee_pkg::NumMask-1:0][cee_pkg::MaskW-1:0] escape_mask;
  logic [cee_pkg::NumMask-1:0][cee_pkg::MaskW-1:0] exception_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mask    <= '0;
      exception_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cee_pkg::CfgEscape0:    escape_mask[0]    <= cfg_data;
        cee_pkg::CfgEscape1:    escape_mask[1]    <= cfg_data;
        cee_pkg::CfgEscape2:    escape_mask[2]    <= cfg_data;
        cee_pkg::CfgEscape3:    escape_mask[3]    <= cfg_data;
        cee_pkg::CfgException0: exception_mask[0] <= cfg_data;
        cee_pkg::CfgException1: exception_mask[1] <= cfg_data;
        cee_pkg::CfgException2: exception_mask[2] <= cfg_data;
        cee_pkg::CfgException3: exception_mask[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign masks.escape    = escape_mask;
  assign masks.exception = exception_mask;

endmodule

@@ hdl/cee_expand.sv @@
`timescale 1ns / 1ps
// cee_expand: input register and the expansion of one source byte into up to five chars
// depends on cee_pkg

module cee_expand (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_stall,
  input  logic [7:0]      src_byte,
  input  logic            src_last,
  input  cee_pkg::masks_t masks,
  input  logic            take,
  output logic            exp_valid,
  output cee_pkg::exp_t   exp
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  logic                                 printable;
  logic                                 esc_hit;
  logic                                 exc_hit;
  logic [7:0]                           letter;
  logic [cee_pkg::MaxOut-1:0][7:0]      base;
  logic [cee_pkg::CntW-1:0]             base_cnt;

  assign src_stall = s1_valid && !take;
  assign exp_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || take) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      s1_byte <= src_byte;
      s1_last <= src_last;
    end
  end

  always_comb begin
    printable = (s1_byte >= cee_pkg::PrintLo) && (s1_byte <= cee_pkg::PrintHi);
    esc_hit   = masks.escape[s1_byte];
    exc_hit   = masks.exception[s1_byte];
    letter    = cee_pkg::short_escape(s1_byte);
    base      = '0;
    base_cnt  = '0;
    if (printable && esc_hit) begin
      base[0]  = cee_pkg::Backslash;
      base[1]  = s1_byte;
      base_cnt = 3'd2;
    end else if (printable || exc_hit) begin
      base[0]  = s1_byte;
      base_cnt = 3'd1;
    end else if (letter != cee_pkg::Nul) begin
      base[0]  = cee_pkg::Backslash;
      base[1]  = letter;
      base_cnt = 3'd2;
    end else begin
      base[0]  = cee_pkg::Backslash;
      base[1]  = cee_pkg::DigitZero + {6'd0, s1_byte[7:6]};
      base[2]  = cee_pkg::DigitZero + {5'd0, s1_byte[5:3]};
      base[3]  = cee_pkg::DigitZero + {5'd0, s1_byte[2:0]};
      base_cnt = 3'd4;
    end
    // terminator slot is already zero; only the count grows
    exp.chars = base;
    exp.cnt   = s1_last ? base_cnt + 3'd1 : base_cnt;
  end

endmodule

@@ hdl/cee_serial.sv @@
`timescale 1ns / 1ps
// cee_serial: output shifter that sends the expanded chars one beat per cycle
// unless out_stall; depends on cee_pkg

module cee_serial (
  input  logic          clk,
  input  logic          rst,
  input  logic          exp_valid,
  input  cee_pkg::exp_t exp,
  output logic          take,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          out_last
);

  logic [cee_pkg::MaxOut-1:0][7:0] chars;
  logic [cee_pkg::CntW-1:0]        cnt;
  logic                            busy;
  logic                            pop;
  logic                            free;

  assign busy = (cnt != '0);
  assign pop  = busy && !out_stall;
  assign free = !busy || (pop && cnt == 3'd1);
  assign take = free && exp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (take) begin
      cnt <= exp.cnt;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chars <= exp.chars;
    end else if (pop) begin
      chars <= {8'd0, chars[cee_pkg::MaxOut-1:1]};
    end
  end

  assign out_valid = busy;
  assign out_char  = chars[0];
  assign out_last  = (cnt == 3'd1);

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for c_escape_expander; sends source strings under several
// escape and exception mask settings, predicts every expanded char and checks each beat
// depends on cee_pkg and the c_escape_expander rtl

module tb;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned PhaseItems   = 34;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned MaxPrinted   = 50;
  localparam int unsigned IdxW         = cee_pkg::CfgIdxW;
  localparam int unsigned SetW         = cee_pkg::NumMask * cee_pkg::MaskW;
  localparam logic [IdxW-1:0] CfgBeyond = 4'd8;
  localparam logic [7:0] FirstLetterEsc = 8'd7;
  localparam logic [7:0] LastLetterEsc  = 8'd13;
  localparam logic [6:0][7:0] EscLetters = "rfvntba";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallRuns} stall_mode_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [IdxW-1:0]             cfg_index = '0;
  logic [cee_pkg::MaskW-1:0]   cfg_data = '0;
  logic                        src_valid = 1'b0;
  logic                        src_stall;
  logic [7:0]                  src_byte = '0;
  logic                        src_last = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [7:0]                  out_char;
  logic                        out_last;

  logic [SetW-1:0] esc_set = '0;
  logic [SetW-1:0] exc_set = '0;
  out_beat_t       expected_chars[$];

  int          mismatches = 0;
  int          items_sent = 0;
  int          strings_sent = 0;
  int          beats_checked = 0;
  int          mask_settings = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  stall_mode_t stall_mode = StallNone;
  int          stall_epoch = 0;

  c_escape_expander dut (.*);

  initial forever #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    if (mismatches < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void predict_expansion(logic [7:0] b, logic l);
    logic [7:0] seq[$];
    if (b >= cee_pkg::PrintLo && b <= cee_pkg::PrintHi) begin
      if (esc_set[b]) seq.push_back(cee_pkg::Backslash);
      seq.push_back(b);
    end else if (exc_set[b]) begin
      seq.push_back(b);
    end else if (b >= FirstLetterEsc && b <= LastLetterEsc) begin
      seq.push_back(cee_pkg::Backslash);
      seq.push_back(EscLetters[b - FirstLetterEsc]);
    end else begin
      seq.push_back(cee_pkg::Backslash);
      seq.push_back(cee_pkg::DigitZero + {6'd0, b[7:6]});
      seq.push_back(cee_pkg::DigitZero + {5'd0, b[5:3]});
      seq.push_back(cee_pkg::DigitZero + {5'd0, b[2:0]});
    end
    if (l) seq.push_back(cee_pkg::Nul);
    foreach (seq[i]) expected_chars.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
  endfunction

  task automatic wait_drained();
    src_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mask(logic [IdxW-1:0] idx, logic [cee_pkg::MaskW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx <= cee_pkg::CfgEscape3) begin
      esc_set[idx * cee_pkg::MaskW +: cee_pkg::MaskW] = data;
    end else if (idx <= cee_pkg::CfgException3) begin
      exc_set[(idx - cee_pkg::CfgException0) * cee_pkg::MaskW +: cee_pkg::MaskW] = data;
    end
  endtask

  task automatic load_masks(logic [SetW-1:0] esc, logic [SetW-1:0] exc);
    wait_drained();
    for (int i = 0; i < cee_pkg::NumMask; i++)
      write_mask(IdxW'(cee_pkg::CfgEscape0 + i), esc[i * cee_pkg::MaskW +: cee_pkg::MaskW]);
    for (int i = 0; i < cee_pkg::NumMask; i++)
      write_mask(IdxW'(cee_pkg::CfgException0 + i), exc[i * cee_pkg::MaskW +: cee_pkg::MaskW]);
    // out-of-range index must leave every mask alone
    write_mask(CfgBeyond | IdxW'($urandom_range(0, 7)), {$urandom, $urandom});
    cfg_we <= 1'b0;
    mask_settings++;
  endtask

  task automatic send_char(logic [7:0] b, logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        src_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    src_valid <= 1'b1;
    src_byte <= b;
    src_last <= l;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    predict_expansion(b, l);
    items_sent++;
    if (l) strings_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(cee_pkg::PrintLo, cee_pkg::PrintHi));
      4, 5:       return 8'($urandom_range(FirstLetterEsc, LastLetterEsc));
      6:          return cee_pkg::Nul;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [SetW-1:0] pick_set();
    logic [SetW-1:0]           s;
    logic [cee_pkg::MaskW-1:0] w;
    for (int i = 0; i < cee_pkg::NumMask; i++) begin
      w = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0:       w = '0;
        1:       w = '1;
        2:       w &= {$urandom, $urandom};
        3:       w |= {$urandom, $urandom};
        default: ;
      endcase
      s[i * cee_pkg::MaskW +: cee_pkg::MaskW] = w;
    end
    return s;
  endfunction

  task automatic test_reset_masks();
    send_char(cee_pkg::Nul, 1'b0);
    send_char(8'h01, 1'b0);
    for (int b = FirstLetterEsc; b <= LastLetterEsc; b++) send_char(8'(b), 1'b0);
    send_char(8'h1F, 1'b0);
    send_char(cee_pkg::PrintLo, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(cee_pkg::Backslash, 1'b0);
    send_char(cee_pkg::PrintHi, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_mask_extremes();
    // escape bits on non-printable bytes have no effect
    load_masks('1, '0);
    send_char(cee_pkg::PrintLo, 1'b0);
    send_char(cee_pkg::PrintHi, 1'b0);
    send_char(FirstLetterEsc, 1'b0);
    send_char(cee_pkg::Nul, 1'b1);
    // exception bits on printable bytes have no effect
    load_masks('0, '1);
    send_char(8'h41, 1'b0);
    send_char(8'h0A, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(cee_pkg::Nul, 1'b1);
    load_masks('1, '1);
    send_char(cee_pkg::Backslash, 1'b0);
    send_char(8'h80, 1'b1);
  endtask

  task automatic test_random_strings();
    int count;
    int len;
    for (int phase = 0; phase < NumPhases; phase++) begin
      load_masks(pick_set(), pick_set());
      steady = (phase == 2);
      count = 0;
      while (count < PhaseItems) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) send_char(pick_byte(), i == len - 1);
        count += len;
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : check_beat
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char %02h last %0b", out_char, out_last));
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch)
          report_mismatch($sformatf("out_char %02h, want %02h", out_char, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("out_last %0b, want %0b (char %02h)",
                                    out_last, want.last, want.ch));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_epoch == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_epoch <= $urandom_range(20, 100);
    end else begin
      stall_epoch <= stall_epoch - 1;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ((stall_epoch / 7) % 2) == 1;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("watchdog: no beat accepted for %0d cycles", IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_masks();
    test_mask_extremes();
    test_random_strings();
    wait_drained();
    $display("sent %0d source bytes in %0d strings under %0d mask settings",
             items_sent, strings_sent, mask_settings + 1);
    $display("checked %0d output beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
